### sv/vwp_pkg.sv
// Shared widths, reset values, command codes and types for the vblank wakeup pacer.
`timescale 1ns / 1ps

package vwp_pkg;

    // Field and state widths.
    localparam int RATE_W  = 10;
    localparam int RED_W   = 30;
    localparam int ALPHA_W = 16;
    localparam int DMAX_W  = 17;
    localparam int DRAW_W  = 32;
    localparam int TIME_W  = 63;
    localparam int IVL_W   = 30;
    localparam int OFS_W   = 33;
    localparam int SUM_W   = 64;
    localparam int ACC_W   = 49;

    // Shared divider geometry.
    localparam int DVD_W = 64;
    localparam int DVS_W = 30;
    localparam int CNT_W = 6;

    // Configuration port geometry.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_RATE  = 2'd0;
    localparam logic [1:0] REG_RED   = 2'd1;
    localparam logic [1:0] REG_ALPHA = 2'd2;
    localparam logic [1:0] REG_DMAX  = 2'd3;

    // Command codes.
    localparam logic [1:0] CMD_REPORT = 2'd0;
    localparam logic [1:0] CMD_VBLANK = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Reset values and constants.
    localparam logic [RATE_W-1:0]  RATE_RESET  = 10'd60;
    localparam logic [RATE_W-1:0]  DEFAULT_HZ  = 10'd60;
    localparam logic [RED_W-1:0]   RED_RESET   = 30'd1650000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd980;
    localparam logic [DMAX_W-1:0]  DMAX_RESET  = 17'd1000;
    localparam logic [IVL_W-1:0]   IVL_RESET   = 30'd16666666;
    localparam logic [IVL_W-1:0]   NS_PER_SEC  = 30'd1000000000;

    // Result bundle of the shared divider.
    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } div_result_t;

endpackage

### sv/vwp_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module vwp_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [vwp_pkg::DVD_W-1:0]  dividend,
    input  logic [vwp_pkg::DVS_W-1:0]  divisor,
    output vwp_pkg::div_result_t       result
);
    import vwp_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;

    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   rem_sub;
    logic             fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        fits      = rem_shift >= {1'b0, dvs_reg};
    end

    // Sequencing of the steps.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[DVS_W-1:0] : rem_shift[DVS_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign result.done = done_reg;
    assign result.quot = dvd_reg;
    assign result.rem  = rem_reg;

endmodule

### sv/vwp_mac.sv
// Registered multiply-accumulate used for the two terms of the decay sum.
`timescale 1ns / 1ps

module vwp_mac (
    input  logic                        clk,
    input  logic                        en,
    input  logic                        clr,
    input  logic [vwp_pkg::DMAX_W-1:0]  op_a,
    input  logic [vwp_pkg::DRAW_W-1:0]  op_b,
    output logic [vwp_pkg::ACC_W-1:0]   acc
);
    import vwp_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;

    // Either start a new sum or add the product to the running one.
    always_comb
    begin
        acc_next = acc_reg;
        if (en)
        begin
            acc_next = (clr ? '0 : acc_reg) + ACC_W'(op_a) * ACC_W'(op_b);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

### sv/vblank_wakeup_pacer.sv
// Frame-pacing timer: rolling draw maximum, vblank mark and wakeup query.
// Vblank mark: recorded on acceptance, the block stays ready.
// Draw report: straight to the clamp when it raises the maximum, else MUL_A, MUL_B, RSTART, RDIV (64 divider steps).
// Wakeup query: QOFF, QDL, QCMP, QOUT, plus the 64-step divide in QDIV that finds the remainder.
// A refresh rate write holds off the input while the divider finds the interval.
// Reset (rst_n, asynchronous, active low) restores the registers and clears the pacing state.
`timescale 1ns / 1ps

module vblank_wakeup_pacer (
    input  logic                        clk,
    input  logic                        rst_n,
    // Input channel.
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  cmd,
    input  logic [vwp_pkg::DRAW_W-1:0]  draw_time_ns,
    input  logic [vwp_pkg::TIME_W-1:0]  vblank_time_ns,
    input  logic [vwp_pkg::TIME_W-1:0]  now_ns,
    // Output channel.
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [vwp_pkg::TIME_W-1:0]  wakeup_ns,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vwp_pkg::ADDR_W-1:0]  paddr,
    input  logic [vwp_pkg::DATA_W-1:0]  pwdata,
    output logic [vwp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import vwp_pkg::*;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RATE   = 4'd1;
    localparam logic [3:0] ST_MUL_A  = 4'd2;
    localparam logic [3:0] ST_MUL_B  = 4'd3;
    localparam logic [3:0] ST_RSTART = 4'd4;
    localparam logic [3:0] ST_RDIV   = 4'd5;
    localparam logic [3:0] ST_CLAMP  = 4'd6;
    localparam logic [3:0] ST_QOFF   = 4'd7;
    localparam logic [3:0] ST_QDL    = 4'd8;
    localparam logic [3:0] ST_QCMP   = 4'd9;
    localparam logic [3:0] ST_QDIV   = 4'd10;
    localparam logic [3:0] ST_QOUT   = 4'd11;

    logic [3:0]         state_reg, state_next;

    // Configuration registers.
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic [RED_W-1:0]   red_reg, red_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [DMAX_W-1:0]  dmax_reg, dmax_next;
    logic               rate_pend_reg, rate_pend_next;

    // Pacing state.
    logic [IVL_W-1:0]   ivl_reg, ivl_next;
    logic [DRAW_W-1:0]  max_reg, max_next;
    logic [TIME_W-1:0]  last_reg, last_next;

    // Per-transaction working registers.
    logic [DRAW_W-1:0]  draw_reg, draw_next;
    logic [DRAW_W-1:0]  cand_reg, cand_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [OFS_W-1:0]   offset_reg, offset_next;
    logic [SUM_W-1:0]   target_reg, target_next;
    logic [SUM_W-1:0]   deadline_reg, deadline_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]  wakeup_reg, wakeup_next;

    // Derived values.
    logic               cfg_wr;
    logic [1:0]         cfg_idx;
    logic               accept;
    logic [DMAX_W-1:0]  dm_eff;
    logic [DMAX_W-1:0]  a_sat;
    logic [RATE_W-1:0]  hz_eff;
    logic [IVL_W-1:0]   cap;
    logic [DRAW_W-1:0]  clamped;
    logic               late;
    logic [SUM_W-1:0]   gap;
    logic [IVL_W-1:0]   adj;
    logic [SUM_W-1:0]   res;
    logic [TIME_W-1:0]  res_sat;
    logic               out_free;

    // Shared unit hookup.
    logic               mac_en;
    logic               mac_clr;
    logic [DMAX_W-1:0]  mac_a;
    logic [DRAW_W-1:0]  mac_b;
    logic [ACC_W-1:0]   mac_acc;
    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    div_result_t        div_res;

    vwp_mac u_mac (
        .clk  (clk),
        .en   (mac_en),
        .clr  (mac_clr),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (mac_acc)
    );

    vwp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .result   (div_res)
    );

    // Handshake and configuration decode.
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || rate_pend_reg;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[3:2];
    assign pready   = 1'b1;
    assign out_free = !out_valid_reg || !out_stall;

    // Effective decay weights and refresh rate.
    always_comb
    begin
        dm_eff = (dmax_reg == '0) ? DMAX_W'(1) : dmax_reg;
        a_sat  = ({1'b0, alpha_reg} > dm_eff) ? dm_eff : {1'b0, alpha_reg};
        hz_eff = (rate_reg == '0) ? DEFAULT_HZ : rate_reg;
    end

    // Clamp of the candidate maximum against interval minus red zone, zero if the red zone reaches the interval.
    always_comb
    begin
        cap = ivl_reg - red_reg;
        if (red_reg < ivl_reg)
        begin
            clamped = (cand_reg > DRAW_W'(cap)) ? DRAW_W'(cap) : cand_reg;
        end
        else
        begin
            clamped = '0;
        end
    end

    // Query arithmetic: step count by remainder, then subtract the offset.
    always_comb
    begin
        late    = target_reg < deadline_reg;
        gap     = deadline_reg - target_reg;
        adj     = (div_res.rem == '0) ? '0 : ivl_reg - div_res.rem;
        res     = target_reg - SUM_W'(offset_reg);
        res_sat = res[SUM_W-1] ? {TIME_W{1'b1}} : res[TIME_W-1:0];
    end

    // Operands of the multiply-accumulate.
    always_comb
    begin
        mac_en  = (state_reg == ST_MUL_A) || (state_reg == ST_MUL_B);
        mac_clr = (state_reg == ST_MUL_A);
        mac_a   = (state_reg == ST_MUL_A) ? a_sat : dm_eff - a_sat;
        mac_b   = (state_reg == ST_MUL_A) ? max_reg : draw_reg;
    end

    // Operands of the divider.
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = SUM_W'(NS_PER_SEC);
        div_dvs   = DVS_W'(hz_eff);
        case (state_reg)
            ST_IDLE:
            begin
                div_start = rate_pend_reg;
            end
            ST_RSTART:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(mac_acc);
                div_dvs   = DVS_W'(dm_eff);
            end
            ST_QCMP:
            begin
                div_start = late;
                div_dvd   = gap;
                div_dvs   = ivl_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        rate_pend_next = rate_pend_reg;
        ivl_next       = ivl_reg;
        max_next       = max_reg;
        last_next      = last_reg;
        draw_next      = draw_reg;
        cand_next      = cand_reg;
        now_next       = now_reg;
        offset_next    = offset_reg;
        target_next    = target_reg;
        deadline_next  = deadline_reg;
        out_valid_next = out_valid_reg && out_stall;
        wakeup_next    = wakeup_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (rate_pend_reg)
                begin
                    rate_pend_next = 1'b0;
                    state_next     = ST_RATE;
                end
                else if (accept)
                begin
                    case (cmd)
                        CMD_REPORT:
                        begin
                            draw_next = draw_time_ns;
                            if (draw_time_ns > max_reg)
                            begin
                                cand_next  = draw_time_ns;
                                state_next = ST_CLAMP;
                            end
                            else
                            begin
                                state_next = ST_MUL_A;
                            end
                        end
                        CMD_VBLANK:
                        begin
                            last_next = vblank_time_ns;
                        end
                        CMD_QUERY:
                        begin
                            now_next   = now_ns;
                            state_next = ST_QOFF;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RATE:
            begin
                if (div_res.done)
                begin
                    ivl_next   = div_res.quot[IVL_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            ST_MUL_A:
            begin
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                state_next = ST_RSTART;
            end
            ST_RSTART:
            begin
                state_next = ST_RDIV;
            end
            ST_RDIV:
            begin
                if (div_res.done)
                begin
                    cand_next  = div_res.quot[DRAW_W-1:0];
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                max_next   = clamped;
                state_next = ST_IDLE;
            end
            ST_QOFF:
            begin
                offset_next = OFS_W'(max_reg) + OFS_W'(red_reg);
                target_next = SUM_W'(last_reg) + SUM_W'(ivl_reg);
                state_next  = ST_QDL;
            end
            ST_QDL:
            begin
                deadline_next = SUM_W'(now_reg) + SUM_W'(offset_reg);
                state_next    = ST_QCMP;
            end
            ST_QCMP:
            begin
                state_next = late ? ST_QDIV : ST_QOUT;
            end
            ST_QDIV:
            begin
                if (div_res.done)
                begin
                    target_next = deadline_reg + SUM_W'(adj);
                    state_next  = ST_QOUT;
                end
            end
            ST_QOUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    wakeup_next    = res_sat;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A rate write asks for a new interval.
        if (cfg_wr && (cfg_idx == REG_RATE))
        begin
            rate_pend_next = 1'b1;
        end
    end

    // Configuration register writes.
    always_comb
    begin
        rate_next  = rate_reg;
        red_next   = red_reg;
        alpha_next = alpha_reg;
        dmax_next  = dmax_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_RATE:  rate_next  = pwdata[RATE_W-1:0];
                REG_RED:   red_next   = pwdata[RED_W-1:0];
                REG_ALPHA: alpha_next = pwdata[ALPHA_W-1:0];
                REG_DMAX:  dmax_next  = pwdata[DMAX_W-1:0];
                default:   rate_next  = rate_reg;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (cfg_idx)
            REG_RATE:  prdata = DATA_W'(rate_reg);
            REG_RED:   prdata = DATA_W'(red_reg);
            REG_ALPHA: prdata = DATA_W'(alpha_reg);
            REG_DMAX:  prdata = DATA_W'(dmax_reg);
            default:   prdata = '0;
        endcase
    end

    // Control and pacing state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= RATE_RESET;
            red_reg       <= RED_RESET;
            alpha_reg     <= ALPHA_RESET;
            dmax_reg      <= DMAX_RESET;
            rate_pend_reg <= 1'b0;
            ivl_reg       <= IVL_RESET;
            max_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rate_reg      <= rate_next;
            red_reg       <= red_next;
            alpha_reg     <= alpha_next;
            dmax_reg      <= dmax_next;
            rate_pend_reg <= rate_pend_next;
            ivl_reg       <= ivl_next;
            max_reg       <= max_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers of the current transaction.
    always_ff @(posedge clk)
    begin
        draw_reg     <= draw_next;
        cand_reg     <= cand_next;
        now_reg      <= now_next;
        offset_reg   <= offset_next;
        target_reg   <= target_next;
        deadline_reg <= deadline_next;
        wakeup_reg   <= wakeup_next;
    end

    assign out_valid = out_valid_reg;
    assign wakeup_ns = wakeup_reg;

endmodule

### sv/vwp_checker.sv
// Port-level checks for the vblank wakeup pacer and their attachment.
`timescale 1ns / 1ps

module vwp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [1:0]                  cmd,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [vwp_pkg::TIME_W-1:0]  wakeup_ns,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [vwp_pkg::ADDR_W-1:0]  paddr,
    input logic [vwp_pkg::DATA_W-1:0]  pwdata,
    input logic [vwp_pkg::DATA_W-1:0]  prdata
);
    import vwp_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(wakeup_ns))
    else $error("result changed while stalled");

    // Reports and queries keep the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == CMD_REPORT || cmd == CMD_QUERY) |=> in_stall)
    else $error("multi-cycle transaction did not hold off the input");

    // A red zone write reads back on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[3:2] == REG_RED
        |=> !psel || paddr[3:2] != REG_RED || prdata == {2'b00, $past(pwdata[RED_W-1:0])})
    else $error("red zone readback mismatch");

endmodule

bind vblank_wakeup_pacer vwp_checker u_vwp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .wakeup_ns (wakeup_ns),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

### sim/testbench.sv
// Self-checking testbench for the vblank wakeup pacer: directed table, random traffic, APB setup.
`timescale 1ns / 1ps

module testbench;
    import vwp_pkg::*;

    localparam logic [1:0]        CMD_SPARE   = 2'd3;
    localparam logic [63:0]       TIME_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]       BILLION     = 64'd1000000000;
    localparam int                PHASES      = 8;
    localparam int                PER_PHASE   = 240;
    localparam int                SETTLE      = 120;
    localparam int                CYCLE_LIMIT = 2000000;
    localparam int                SHOW_MAX    = 10;

    // One input transaction, with an optional hand-computed wakeup.
    typedef struct packed {
        logic [1:0]        op;
        logic [DRAW_W-1:0] draw;
        logic [TIME_W-1:0] vb;
        logic [TIME_W-1:0] now;
        logic              known;
        logic [TIME_W-1:0] want;
    } event_t;

    // One set of register values.
    typedef struct packed {
        logic [RATE_W-1:0]  rate;
        logic [RED_W-1:0]   red;
        logic [ALPHA_W-1:0] alpha;
        logic [DMAX_W-1:0]  dmax;
    } setting_t;

    logic                clk;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic [1:0]          cmd            = CMD_REPORT;
    logic [DRAW_W-1:0]   draw_time_ns   = '0;
    logic [TIME_W-1:0]   vblank_time_ns = '0;
    logic [TIME_W-1:0]   now_ns         = '0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic [TIME_W-1:0]   wakeup_ns;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ADDR_W-1:0]   paddr          = '0;
    logic [DATA_W-1:0]   pwdata         = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Shadow of the pacing state and the registers.
    logic [RATE_W-1:0]   cfg_rate;
    logic [RED_W-1:0]    cfg_red;
    logic [ALPHA_W-1:0]  cfg_alpha;
    logic [DMAX_W-1:0]   cfg_dmax;
    logic [DRAW_W-1:0]   peak_draw;
    logic [TIME_W-1:0]   last_vb;
    logic [IVL_W-1:0]    frame_ns;

    logic [TIME_W-1:0]   wakeup_due[$];
    int                  mismatches = 0;
    int                  cycles     = 0;
    logic                calm       = 1'b0;

    // Directed transactions; a set known bit means the wakeup is typed in by hand.
    event_t opening [0:21] = '{
        '{CMD_QUERY,  32'd0,          63'd0,       63'd0,       1'b1, 63'd15016666},
        '{CMD_SPARE,  '1,             '1,          '1,          1'b0, 63'd0},
        '{CMD_QUERY,  32'd0,          63'd0,       63'd0,       1'b1, 63'd15016666},
        '{CMD_REPORT, 32'd0,          63'd0,       63'd0,       1'b0, 63'd0},
        '{CMD_QUERY,  32'd0,          63'd0,       63'd0,       1'b1, 63'd15016666},
        '{CMD_REPORT, 32'hFFFF_FFFF,  63'd0,       63'd0,       1'b0, 63'd0},
        '{CMD_QUERY,  32'd0,          63'd0,       63'd0,       1'b1, 63'd0},
        '{CMD_REPORT, 32'd1000000,    63'd0,       63'd0,       1'b0, 63'd0},
        '{CMD_QUERY,  32'd0,          63'd0,       63'd5,       1'b0, 63'd0},
        '{CMD_VBLANK, 32'd0,          '1,          63'd0,       1'b0, 63'd0},
        '{CMD_QUERY,  32'd0,          63'd0,       63'd0,       1'b1, '1},
        '{CMD_QUERY,  32'd0,          63'd0,       '1,          1'b0, 63'd0},
        '{CMD_VBLANK, 32'd0,          63'd0,       63'd0,       1'b0, 63'd0},
        '{CMD_QUERY,  32'd0,          63'd0,       '1,          1'b0, 63'd0},
        '{CMD_REPORT, 32'hAAAA_AAAA,  63'd0,       63'd0,       1'b0, 63'd0},
        '{CMD_REPORT, 32'h5555_5555,  63'd0,       63'd0,       1'b0, 63'd0},
        '{CMD_VBLANK, 32'd0,          63'h2AAA_AAAA_AAAA_AAAA, 63'd0, 1'b0, 63'd0},
        '{CMD_QUERY,  32'd0,          63'd0,       63'h5555_5555_5555_5555, 1'b0, 63'd0},
        '{CMD_REPORT, 32'd1,          63'd0,       63'd0,       1'b0, 63'd0},
        '{CMD_QUERY,  32'd0,          63'd0,       63'd123456789, 1'b0, 63'd0},
        '{CMD_VBLANK, 32'd0,          63'd1000,    63'd0,       1'b0, 63'd0},
        '{CMD_QUERY,  32'd0,          63'd0,       63'd1000,    1'b0, 63'd0}
    };

    // Fixed register settings: the extremes and the special denominators.
    setting_t fixed_settings [0:4] = '{
        '{10'd1000, 30'd0,          16'd0,     17'd1},
        '{10'd0,    30'd1000000000, 16'd65535, 17'd65536},
        '{10'd1,    30'd1650000,    16'd65535, 17'd0},
        '{10'd1023, 30'h3FFF_FFFF,  16'd0,     17'd131071},
        '{10'd144,  30'd2000000,    16'd900,   17'd1000}
    };

    vblank_wakeup_pacer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .draw_time_ns   (draw_time_ns),
        .vblank_time_ns (vblank_time_ns),
        .now_ns         (now_ns),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .wakeup_ns      (wakeup_ns),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Free-running clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Frame period for a refresh rate, with zero standing for sixty hertz.
    function automatic logic [IVL_W-1:0] period_for(input logic [RATE_W-1:0] hz);
        logic [63:0] h;
        logic [63:0] q;
        h = (hz == '0) ? 64'd60 : 64'(hz);
        q = BILLION / h;
        return q[IVL_W-1:0];
    endfunction

    // Folds one draw report into the rolling maximum, then clamps it below the red zone.
    function automatic void fold_draw(input logic [DRAW_W-1:0] draw);
        logic [63:0] dm;
        logic [63:0] a;
        logic [63:0] m;
        logic [63:0] cap;
        dm = (cfg_dmax == '0) ? 64'd1 : 64'(cfg_dmax);
        a  = (64'(cfg_alpha) > dm) ? dm : 64'(cfg_alpha);
        m  = 64'(peak_draw);
        if (64'(draw) > m)
            m = 64'(draw);
        else
            m = (a * m + (dm - a) * 64'(draw)) / dm;
        if (cfg_red < frame_ns)
        begin
            cap = 64'(frame_ns) - 64'(cfg_red);
            if (m > cap)
                m = cap;
        end
        else
            m = 64'd0;
        peak_draw = m[DRAW_W-1:0];
    endfunction

    // First vblank after the last mark whose wake time is not before now.
    function automatic logic [TIME_W-1:0] wake_time(input logic [TIME_W-1:0] now);
        logic [63:0] offset;
        logic [63:0] target;
        logic [63:0] deadline;
        logic [63:0] gap;
        logic [63:0] steps;
        logic [63:0] res;
        offset   = 64'(peak_draw) + 64'(cfg_red);
        target   = 64'(last_vb) + 64'(frame_ns);
        deadline = 64'(now) + offset;
        if (target < deadline)
        begin
            gap    = deadline - target;
            steps  = (gap + 64'(frame_ns) - 64'd1) / 64'(frame_ns);
            target = target + steps * 64'(frame_ns);
        end
        res = target - offset;
        if (res > TIME_MAX)
            res = TIME_MAX;
        return res[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    // Random transaction: mostly a plausible frame sequence, some noise.
    function automatic event_t random_event();
        event_t e;
        int     pick;
        pick    = $urandom_range(0, 99);
        e.draw  = $urandom;
        e.vb    = rand_time();
        e.now   = rand_time();
        e.known = 1'b0;
        e.want  = '0;
        if (pick < 25)
        begin
            e.op = CMD_VBLANK;
            if ($urandom_range(0, 19) != 0)
                e.vb = last_vb + TIME_W'(frame_ns) * TIME_W'($urandom_range(1, 2))
                       + TIME_W'($urandom_range(0, 200000));
        end
        else if (pick < 55)
        begin
            e.op = CMD_REPORT;
            if ($urandom_range(0, 4) != 0)
                e.draw = $urandom_range(0, 20000000);
        end
        else if (pick < 95)
        begin
            e.op = CMD_QUERY;
            if ($urandom_range(0, 9) != 0)
                e.now = last_vb + TIME_W'($urandom_range(0, 3 * frame_ns));
        end
        else
            e.op = CMD_SPARE;
        return e;
    endfunction

    // Random register setting.
    function automatic setting_t random_setting();
        setting_t s;
        s.rate  = RATE_W'($urandom_range(0, 1023));
        s.red   = RED_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 30'h3FFF_FFFF)
                                                      : $urandom_range(0, 3000000));
        s.alpha = ALPHA_W'($urandom_range(0, 65535));
        s.dmax  = DMAX_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 131071)
                          : 32'(s.alpha) + $urandom_range(1, 2000));
        return s;
    endfunction

    // Presents one transaction and updates the shadow state once it is taken.
    task automatic offer_event(input event_t e);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= e.op;
        draw_time_ns   <= e.draw;
        vblank_time_ns <= e.vb;
        now_ns         <= e.now;
        do
            @(posedge clk);
        while (in_stall);
        case (e.op)
            CMD_REPORT: fold_draw(e.draw);
            CMD_VBLANK: last_vb = e.vb;
            CMD_QUERY:  wakeup_due.push_back(e.known ? e.want : wake_time(e.now));
            default:    ;
        endcase
    endtask

    // Drops valid and waits for every pending wakeup.
    task automatic drain_wakeups();
        @(negedge clk);
        in_valid <= 1'b0;
        while (wakeup_due.size() != 0)
            @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_RATE:
            begin
                cfg_rate = val[RATE_W-1:0];
                frame_ns = period_for(cfg_rate);
            end
            REG_RED:   cfg_red   = val[RED_W-1:0];
            REG_ALPHA: cfg_alpha = val[ALPHA_W-1:0];
            default:   cfg_dmax  = val[DMAX_W-1:0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input setting_t s);
        write_reg(REG_RATE,  DATA_W'(s.rate));
        write_reg(REG_RED,   DATA_W'(s.red));
        write_reg(REG_ALPHA, DATA_W'(s.alpha));
        write_reg(REG_DMAX,  DATA_W'(s.dmax));
    endtask

    task automatic note_mismatch(input string what, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
        mismatches++;
        if (mismatches <= SHOW_MAX)
            $display("mismatch at cycle %0d: %s, expected %0d, got %0d",
                     cycles, what, want, got);
    endtask

    // Receiver stalls at random outside the calm phase.
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 37);

    // Compare each accepted wakeup with the oldest pending one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (wakeup_due.size() == 0)
                note_mismatch("wakeup with none pending", '0, wakeup_ns);
            else
            begin
                logic [TIME_W-1:0] want;
                want = wakeup_due.pop_front();
                if (wakeup_ns !== want)
                    note_mismatch("wakeup_ns", want, wakeup_ns);
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then phases of random traffic.
    initial
    begin
        cfg_rate  = RATE_RESET;
        cfg_red   = RED_RESET;
        cfg_alpha = ALPHA_RESET;
        cfg_dmax  = DMAX_RESET;
        peak_draw = '0;
        last_vb   = '0;
        frame_ns  = period_for(RATE_RESET);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening[i])
            offer_event(opening[i]);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_wakeups();
            repeat (SETTLE) @(posedge clk);
            apply_setting(p < 5 ? fixed_settings[p] : random_setting());
            calm = (p == 2);
            for (int n = 0; n < PER_PHASE; n++)
            begin
                // Occasionally hold off until the block has caught up.
                if (n == 120 || $urandom_range(0, 99) == 0)
                    drain_wakeups();
                offer_event(random_event());
            end
            calm = 1'b0;
        end

        drain_wakeups();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
